// ===== rtl/vmb_pkg.sv =====
// Package for the vertical motion blur block.
// Holds pixel payload types, register map codes and reset values.
// No dependencies.
package vmb_pkg;

  localparam int unsigned CFG_AW = 4;
  localparam int unsigned CFG_DW = 32;

  // register index, taken from paddr[3:2]
  localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [1:0] REG_BLUR_AMOUNT  = 2'd2;

  localparam logic [10:0] IMAGE_WIDTH_RST  = 11'd512;
  localparam logic [10:0] IMAGE_HEIGHT_RST = 11'd512;
  localparam logic [6:0]  BLUR_AMOUNT_RST  = 7'd8;

  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } pixel_in_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       frame_end;
  } pixel_out_t;

endpackage

// ===== rtl/vmb_ram.sv =====
// Generic single-write, single-read RAM with registered read (read-first).
// No dependencies.
module vmb_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/vmb_front.sv =====
// Front end: raster counters, line store and column sum update.
// Depends on vmb_pkg and vmb_ram.
module vmb_front
  import vmb_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024,
  parameter int unsigned MAX_BLUR   = 64,
  parameter int unsigned QDEPTH     = 4,
  localparam int unsigned SUM_W     = $clog2(MAX_BLUR * 255 + 1),
  localparam int unsigned BL_W      = $clog2(MAX_BLUR + 1),
  localparam int unsigned QC_W      = $clog2(QDEPTH + 1)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [10:0]          image_width,
  input  logic [10:0]          image_height,
  input  logic [6:0]           blur_amount,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  pixel_in_t            in_data,
  input  logic [QC_W-1:0]      q_count,
  output logic                 push_valid,
  output logic [23:0]          push_pix,
  output logic [3*SUM_W-1:0]   push_sums,
  output logic [BL_W-1:0]      push_n,
  output logic                 push_y0,
  output logic                 push_fe
);

  localparam int unsigned COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned SLOT_W = (MAX_BLUR > 1) ? $clog2(MAX_BLUR) : 1;
  localparam int unsigned LS_D   = MAX_BLUR * MAX_WIDTH;
  localparam int unsigned LS_AW  = $clog2(LS_D);
  localparam int unsigned CS_AW  = $clog2(MAX_WIDTH);
  localparam int unsigned BLUR_RST = (8 > MAX_BLUR) ? MAX_BLUR : 8;

  logic [COL_W-1:0]  col_r;
  logic [ROW_W-1:0]  row_r;
  logic [SLOT_W-1:0] slot_r;
  logic [BL_W-1:0]   blur_lat_r;

  logic              accept;
  logic              first_px;
  logic [31:0]       w_eff, h_eff, b_cfg;
  logic [BL_W-1:0]   blur_cur;
  logic [BL_W-1:0]   n_cur;
  logic              grow;
  logic              last_col, last_row;
  logic [31:0]       old_slot_tmp;
  logic [SLOT_W-1:0] old_slot;
  logic [LS_AW-1:0]  ls_waddr, ls_raddr;
  logic [23:0]       ls_q;
  logic [3*SUM_W-1:0] cs_q;

  // stage 1: RAM data is back
  logic               s1_valid_r;
  logic [23:0]        s1_pix_r;
  logic [COL_W-1:0]   s1_col_r;
  logic               s1_y0_r, s1_grow_r, s1_fe_r;
  logic [BL_W-1:0]    s1_n_r;

  logic               fwd_valid_r;
  logic [COL_W-1:0]   fwd_col_r;
  logic [3*SUM_W-1:0] fwd_sum_r;

  logic [3*SUM_W-1:0] sum_old, sum_nxt;
  logic [23:0]        pix_in;

  assign pix_in = {in_data.blue_in, in_data.green_in, in_data.red_in};

  // stall while the queue plus the stage in flight could fill it
  assign in_stall = (32'(q_count) + 32'(s1_valid_r)) >= QDEPTH;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    w_eff = 32'(image_width);
    if (w_eff == 0) w_eff = 1;
    else if (w_eff > MAX_WIDTH) w_eff = MAX_WIDTH;
    h_eff = 32'(image_height);
    if (h_eff == 0) h_eff = 1;
    else if (h_eff > MAX_HEIGHT) h_eff = MAX_HEIGHT;
    b_cfg = 32'(blur_amount);
    if (b_cfg == 0) b_cfg = 1;
    else if (b_cfg > MAX_BLUR) b_cfg = MAX_BLUR;
  end

  assign first_px = (row_r == '0) && (col_r == '0);
  assign blur_cur = first_px ? BL_W'(b_cfg) : blur_lat_r;
  assign n_cur    = (32'(row_r) < 32'(blur_cur)) ? BL_W'(row_r) : blur_cur;
  assign grow     = (32'(row_r) + 1) <= 32'(blur_cur);
  assign last_col = (32'(col_r) + 1) >= w_eff;
  assign last_row = (32'(row_r) + 1) >= h_eff;

  always_comb begin
    old_slot_tmp = 32'(slot_r) + MAX_BLUR - 32'(blur_cur);
    if (old_slot_tmp >= MAX_BLUR) old_slot_tmp = old_slot_tmp - MAX_BLUR;
    old_slot = SLOT_W'(old_slot_tmp);
  end

  assign ls_waddr = LS_AW'(32'(slot_r) * MAX_WIDTH + 32'(col_r));
  assign ls_raddr = LS_AW'(32'(old_slot) * MAX_WIDTH + 32'(col_r));

  vmb_ram #(.WIDTH(24), .DEPTH(LS_D)) u_line_store (
    .clk   (clk),
    .we    (accept),
    .waddr (ls_waddr),
    .wdata (pix_in),
    .re    (accept),
    .raddr (ls_raddr),
    .rdata (ls_q)
  );

  vmb_ram #(.WIDTH(3 * SUM_W), .DEPTH(MAX_WIDTH)) u_col_sums (
    .clk   (clk),
    .we    (s1_valid_r),
    .waddr (CS_AW'(s1_col_r)),
    .wdata (sum_nxt),
    .re    (accept),
    .raddr (CS_AW'(col_r)),
    .rdata (cs_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      slot_r     <= '0;
      blur_lat_r <= BL_W'(BLUR_RST);
    end else if (accept) begin
      if (first_px) blur_lat_r <= BL_W'(b_cfg);
      if (last_col) begin
        col_r <= '0;
        if (last_row) begin
          row_r  <= '0;
          slot_r <= '0;
        end else begin
          row_r  <= row_r + 1'b1;
          slot_r <= (32'(slot_r) == MAX_BLUR - 1) ? '0 : SLOT_W'(32'(slot_r) + 1);
        end
      end else begin
        col_r <= col_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      fwd_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= accept;
      fwd_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix_r  <= pix_in;
      s1_col_r  <= col_r;
      s1_y0_r   <= (row_r == '0);
      s1_grow_r <= grow;
      s1_n_r    <= n_cur;
      s1_fe_r   <= last_col && last_row;
    end
    fwd_col_r <= s1_col_r;
    fwd_sum_r <= sum_nxt;
  end

  // the write of the previous cycle is not yet visible in the RAM read
  assign sum_old = (fwd_valid_r && (fwd_col_r == s1_col_r)) ? fwd_sum_r : cs_q;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (s1_y0_r) begin
        sum_nxt[c*SUM_W +: SUM_W] = SUM_W'(s1_pix_r[c*8 +: 8]);
      end else if (s1_grow_r) begin
        sum_nxt[c*SUM_W +: SUM_W] = sum_old[c*SUM_W +: SUM_W] + SUM_W'(s1_pix_r[c*8 +: 8]);
      end else begin
        sum_nxt[c*SUM_W +: SUM_W] = sum_old[c*SUM_W +: SUM_W]
                                    + SUM_W'(s1_pix_r[c*8 +: 8])
                                    - SUM_W'(ls_q[c*8 +: 8]);
      end
    end
  end

  assign push_valid = s1_valid_r;
  assign push_pix   = s1_pix_r;
  assign push_sums  = sum_old;
  assign push_n     = s1_n_r;
  assign push_y0    = s1_y0_r;
  assign push_fe    = s1_fe_r;

endmodule

// ===== rtl/vmb_queue.sv =====
// Short register FIFO between front and back.
// No dependencies.
module vmb_queue #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4,
  localparam int unsigned PW   = $clog2(DEPTH),
  localparam int unsigned CW   = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic             q_valid,
  output logic [WIDTH-1:0] q_data,
  output logic [CW-1:0]    q_count
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_r, rd_r;
  logic [CW-1:0]    cnt_r;
  logic             do_pop;

  assign q_valid = (cnt_r != '0);
  assign do_pop  = pop && q_valid;
  assign q_data  = mem_r[rd_r];
  assign q_count = cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= (32'(wr_r) == DEPTH - 1) ? '0 : wr_r + 1'b1;
      if (do_pop) rd_r <= (32'(rd_r) == DEPTH - 1) ? '0 : rd_r + 1'b1;
      cnt_r <= cnt_r + CW'(push) - CW'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= push_data;
  end

endmodule

// ===== rtl/vmb_back.sv =====
// Back end: reciprocal-multiply divide by 2n, add half pixel, output register.
// Depends on vmb_pkg.
module vmb_back
  import vmb_pkg::*;
#(
  parameter int unsigned MAX_BLUR = 64,
  localparam int unsigned SUM_W   = $clog2(MAX_BLUR * 255 + 1),
  localparam int unsigned BL_W    = $clog2(MAX_BLUR + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  logic [23:0]        q_pix,
  input  logic [3*SUM_W-1:0] q_sums,
  input  logic [BL_W-1:0]    q_n,
  input  logic               q_y0,
  input  logic               q_fe,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output pixel_out_t         out_data
);

  // floor(S/(2n)) = floor((S>>1)/n), done as ((S>>1) * ceil(2^K/n)) >> K
  localparam int unsigned DIV_N = SUM_W - 1;
  localparam int unsigned DIV_L = $clog2(MAX_BLUR);
  localparam int unsigned DIV_K = DIV_N + DIV_L;
  localparam int unsigned PROD_W = DIV_N + DIV_K + 1;

  logic [DIV_K:0] recip [MAX_BLUR + 1];

  for (genvar i = 0; i <= MAX_BLUR; i++) begin : g_recip
    localparam int unsigned RV = (i == 0) ? 0 : ((2 ** DIV_K) + i - 1) / i;
    assign recip[i] = (DIV_K + 1)'(RV);
  end

  logic              advance;
  logic              m_valid_r;
  logic [PROD_W-1:0] m_prod_r [3];
  logic [23:0]       m_pix_r;
  logic              m_y0_r, m_fe_r;
  logic              out_valid_r;
  pixel_out_t        out_data_r;
  logic [7:0]        res [3];

  assign advance = !(out_valid_r && out_stall);
  assign q_pop   = advance && q_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      m_valid_r   <= q_valid;
      out_valid_r <= m_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int c = 0; c < 3; c++) begin
        m_prod_r[c] <= PROD_W'(q_sums[c*SUM_W+1 +: DIV_N]) * PROD_W'(recip[q_n]);
      end
      m_pix_r <= q_pix;
      m_y0_r  <= q_y0;
      m_fe_r  <= q_fe;
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (m_y0_r) begin
        res[c] = m_pix_r[c*8 +: 8];
      end else begin
        res[c] = 8'(m_pix_r[c*8+1 +: 7]) + 8'(m_prod_r[c] >> DIV_K);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r.red_out   <= res[0];
      out_data_r.green_out <= res[1];
      out_data_r.blue_out  <= res[2];
      out_data_r.frame_end <= m_fe_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/vertical_motion_blur.sv =====
// Vertical motion blur: raster RGB pixels in, one blurred pixel out per pixel.
// Row 0 of a frame passes through; each later pixel becomes half itself plus
// the mean of up to blur_amount original pixels above it, halved. The block
// takes one pixel every cycle when the output is not stalled. The rate is set
// by the line store RAM (one write and one read per pixel) and the column
// sum RAM, whose read-modify-write has a bypass for images one pixel wide.
// No clearing pass is run after reset. blur_amount is latched on the first
// pixel of each frame; the size registers act at once.
// Depends on vmb_pkg, vmb_ram, vmb_front, vmb_queue and vmb_back.
module vertical_motion_blur
  import vmb_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024,
  parameter int unsigned MAX_BLUR   = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  // pixel input
  input  logic              in_valid,
  output logic              in_stall,
  input  pixel_in_t         in_data,
  // blurred pixel output
  output logic              out_valid,
  input  logic              out_stall,
  output pixel_out_t        out_data,
  // register port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned SUM_W  = $clog2(MAX_BLUR * 255 + 1);
  localparam int unsigned BL_W   = $clog2(MAX_BLUR + 1);
  localparam int unsigned QC_W   = $clog2(QDEPTH + 1);
  localparam int unsigned QW     = 24 + 3 * SUM_W + BL_W + 2;

  logic [10:0] image_width_r;
  logic [10:0] image_height_r;
  logic [6:0]  blur_amount_r;
  logic        cfg_wr;

  // Register file: write on the access phase, no wait states.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= IMAGE_WIDTH_RST;
      image_height_r <= IMAGE_HEIGHT_RST;
      blur_amount_r  <= BLUR_AMOUNT_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_IMAGE_WIDTH:  image_width_r  <= pwdata[10:0];
        REG_IMAGE_HEIGHT: image_height_r <= pwdata[10:0];
        REG_BLUR_AMOUNT:  blur_amount_r  <= pwdata[6:0];
        default: ;  // drop writes to unmapped addresses
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_IMAGE_WIDTH:  prdata = CFG_DW'(image_width_r);
      REG_IMAGE_HEIGHT: prdata = CFG_DW'(image_height_r);
      REG_BLUR_AMOUNT:  prdata = CFG_DW'(blur_amount_r);
      default:          prdata = '0;
    endcase
  end

  // Front end: counters, line store and running column sums.
  logic               push_valid;
  logic [23:0]        push_pix;
  logic [3*SUM_W-1:0] push_sums;
  logic [BL_W-1:0]    push_n;
  logic               push_y0, push_fe;
  logic [QC_W-1:0]    q_count;

  vmb_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_BLUR   (MAX_BLUR),
    .QDEPTH     (QDEPTH)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .image_width  (image_width_r),
    .image_height (image_height_r),
    .blur_amount  (blur_amount_r),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .q_count      (q_count),
    .push_valid   (push_valid),
    .push_pix     (push_pix),
    .push_sums    (push_sums),
    .push_n       (push_n),
    .push_y0      (push_y0),
    .push_fe      (push_fe)
  );

  // Queue decouples the RAM pipeline from output backpressure; the front
  // holds off while its in-flight transfer could overrun it.
  logic          q_valid, q_pop;
  logic [QW-1:0] q_data;

  vmb_queue #(.WIDTH(QW), .DEPTH(QDEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push_valid),
    .push_data ({push_pix, push_sums, push_n, push_y0, push_fe}),
    .pop       (q_pop),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_count   (q_count)
  );

  // Back end: divide, combine and present the result.
  vmb_back #(.MAX_BLUR(MAX_BLUR)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_pix     (q_data[QW-1 -: 24]),
    .q_sums    (q_data[BL_W+2 +: 3*SUM_W]),
    .q_n       (q_data[2 +: BL_W]),
    .q_y0      (q_data[1]),
    .q_fe      (q_data[0]),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
